/* design/assert_macros.svh */
// Assertion macros shared by the word normalizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define UWN_CHECK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Check a property at every clock edge, reset included.
`define UWN_CHECK_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

/* design/uwn_pkg.sv */
// Types, constants and decode functions of the UTF-8 word normalizer.
package uwn_pkg;

   // Widths fixed by the longest word (64 bytes).
   localparam int CNT_W = 7;
   localparam int IDX_W = 6;
   localparam int HALF_IDX_W = 5;

   // Character codes.
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // Cyrillic lead and second bytes.
   localparam logic [7:0] LEAD_D0 = 8'hD0;
   localparam logic [7:0] LEAD_D1 = 8'hD1;
   localparam logic [7:0] YO_UPPER = 8'h81;
   localparam logic [7:0] YO_LOWER = 8'h91;

   typedef enum logic [2:0] {
      ST_BYTE   = 3'd0,
      ST_EMPTY  = 3'd1,
      ST_HYPHEN = 3'd2,
      ST_TRUNC  = 3'd3,
      ST_LONG   = 3'd4
   } uwn_status_type;

   typedef enum logic {
      BK_IDLE,
      BK_SHOW
   } uwn_back_state_type;

   // One finished word, handed from front to back.
   typedef struct packed {
      logic                 bank;
      logic [CNT_W-1:0]     count;
      uwn_status_type       status;
   } uwn_desc_type;

   // Write port into the split (even/odd) word store.
   typedef struct packed {
      logic                  bank;
      logic                  even_we;
      logic [HALF_IDX_W-1:0] even_idx;
      logic [7:0]            even_data;
      logic                  odd_we;
      logic [HALF_IDX_W-1:0] odd_idx;
      logic [7:0]            odd_data;
   } uwn_wr_type;

   // Result of mapping a two-byte symbol.
   typedef struct packed {
      logic       keep;
      logic [7:0] b0;
      logic [7:0] b1;
   } uwn_pair_type;

   // Bytes still owed after a lead byte.
   function automatic logic [2:0] uwn_pending(input logic [7:0] b);
      logic [2:0] p;
      if (b < 8'hC0)       p = 3'd0;
      else if (b < 8'hE0)  p = 3'd1;
      else if (b < 8'hF0)  p = 3'd2;
      else if (b < 8'hF8)  p = 3'd3;
      else if (b < 8'hFC)  p = 3'd4;
      else if (b < 8'hFE)  p = 3'd5;
      else if (b == 8'hFE) p = 3'd6;
      else                 p = 3'd7;
      return p;
   endfunction

   // Keep Cyrillic letters, folding uppercase to lowercase.
   function automatic uwn_pair_type uwn_pair_map(input logic [7:0] lead,
                                                 input logic [7:0] s);
      uwn_pair_type r;
      r = '0;
      if (lead == LEAD_D0) begin
         if (s >= 8'h90 && s <= 8'h9F) begin
            r = '{keep: 1'b1, b0: LEAD_D0, b1: s + CASE_OFFSET};
         end else if (s >= 8'hA0 && s <= 8'hAF) begin
            r = '{keep: 1'b1, b0: LEAD_D1, b1: s - CASE_OFFSET};
         end else if (s == YO_UPPER) begin
            r = '{keep: 1'b1, b0: LEAD_D1, b1: YO_LOWER};
         end else if (s >= 8'hB0 && s <= 8'hBF) begin
            r = '{keep: 1'b1, b0: LEAD_D0, b1: s};
         end
      end else if (lead == LEAD_D1) begin
         if ((s >= 8'h80 && s <= 8'h8F) || s == YO_LOWER) begin
            r = '{keep: 1'b1, b0: LEAD_D1, b1: s};
         end
      end
      return r;
   endfunction

endpackage

/* design/uwn_req_if.sv */
// Input byte channel of the word normalizer.
interface uwn_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       word_end;

   modport source (output valid, output in_byte, output word_end, input ready);
   modport sink (input valid, input in_byte, input word_end, output ready);
endinterface

/* design/uwn_rsp_if.sv */
// Result channel of the word normalizer.
interface uwn_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [2:0] status;
   logic       run_last;

   modport source (output valid, output out_byte, output status, output run_last,
                   input ready);
   modport sink (input valid, input out_byte, input status, input run_last,
                 output ready);
endinterface

/* design/uwn_front.sv */
// Front end: accepts bytes, decodes symbols, writes kept bytes, closes words.
`include "assert_macros.svh"

module uwn_front
   import uwn_pkg::*;
#(
   parameter int MAX_WORD = 64
) (
   input  logic         clock,
   input  logic         reset,
   uwn_req_if.sink      req,
   input  logic         word_done,
   output logic         push,
   output uwn_desc_type desc,
   output uwn_wr_type   wr
);

   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             hyph_ff, hyph_in;
   logic             start_ff, start_in;
   logic [2:0]       pend_ff, pend_in;
   logic [7:0]       lead_ff, lead_in;
   logic             pair_ff, pair_in;
   logic             ovf_ff, ovf_in;
   logic             first_hy_ff, first_hy_in;
   logic             bank_ff, bank_in;
   logic [1:0]       flight_ff, flight_in;
   logic             accept;

   // Stall while both banks hold words not yet drained.
   assign req.ready = (flight_ff != 2'd2);
   assign accept = req.valid && req.ready;

   // Decode one byte and update the word state.
   always_comb begin
      logic [7:0]       b;
      logic             keep1;
      logic             keep2;
      logic [7:0]       d0;
      logic [7:0]       d1;
      logic [CNT_W-1:0] pos1;
      uwn_pair_type     pm;
      uwn_status_type   st;

      b = req.in_byte;
      keep1 = 1'b0;
      keep2 = 1'b0;
      d0 = b;
      d1 = 8'h00;
      pos1 = fill_ff + CNT_W'(1);
      pm = uwn_pair_map(lead_ff, b);
      st = ST_BYTE;

      fill_in = fill_ff;
      hyph_in = hyph_ff;
      start_in = start_ff;
      pend_in = pend_ff;
      lead_in = lead_ff;
      pair_in = pair_ff;
      ovf_in = ovf_ff;
      first_hy_in = first_hy_ff;
      bank_in = bank_ff;
      wr = '0;
      wr.bank = bank_ff;
      push = 1'b0;
      desc = '0;

      if (accept) begin
         // Classify the byte.
         if (pend_ff != 3'd0) begin
            pend_in = pend_ff - 3'd1;
            if (pair_ff && pend_ff == 3'd1) begin
               keep2 = pm.keep;
               d0 = pm.b0;
               d1 = pm.b1;
               pair_in = 1'b0;
            end
         end else if (b < 8'hC0) begin
            if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
               keep1 = 1'b1;
               d0 = b + CASE_OFFSET;
            end else if ((b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) ||
                         (b >= CHAR_DIGIT_0 && b <= CHAR_DIGIT_9)) begin
               keep1 = 1'b1;
            end else if (b == CHAR_HYPHEN && !hyph_ff && !start_ff && !req.word_end) begin
               keep1 = 1'b1;
               hyph_in = 1'b1;
            end
         end else if (b < 8'hE0) begin
            lead_in = b;
            pair_in = 1'b1;
            pend_in = 3'd1;
         end else begin
            pair_in = 1'b0;
            pend_in = uwn_pending(b);
         end
         start_in = 1'b0;

         // Store one kept byte.
         if (keep1) begin
            if (fill_ff < CNT_W'(MAX_WORD)) begin
               if (!fill_ff[0]) begin
                  wr.even_we = 1'b1;
                  wr.even_idx = fill_ff[IDX_W-1:1];
                  wr.even_data = d0;
               end else begin
                  wr.odd_we = 1'b1;
                  wr.odd_idx = fill_ff[IDX_W-1:1];
                  wr.odd_data = d0;
               end
               fill_in = pos1;
               if (fill_ff == '0 && d0 == CHAR_HYPHEN) begin
                  first_hy_in = 1'b1;
               end
            end else begin
               ovf_in = 1'b1;
            end
         end

         // Store a kept pair, one byte in each half of the store.
         if (keep2) begin
            if (fill_ff <= CNT_W'(MAX_WORD - 2)) begin
               wr.even_we = 1'b1;
               wr.odd_we = 1'b1;
               if (!fill_ff[0]) begin
                  wr.even_idx = fill_ff[IDX_W-1:1];
                  wr.even_data = d0;
                  wr.odd_idx = fill_ff[IDX_W-1:1];
                  wr.odd_data = d1;
               end else begin
                  wr.odd_idx = fill_ff[IDX_W-1:1];
                  wr.odd_data = d0;
                  wr.even_idx = pos1[IDX_W-1:1];
                  wr.even_data = d1;
               end
               fill_in = fill_ff + CNT_W'(2);
            end else begin
               ovf_in = 1'b1;
            end
         end

         // Close the word and hand it to the back end.
         if (req.word_end) begin
            if (pend_in != 3'd0) begin
               st = ST_TRUNC;
            end else if (ovf_in) begin
               st = ST_LONG;
            end else if (fill_in == '0) begin
               st = ST_EMPTY;
            end else if (fill_in == CNT_W'(1) && first_hy_in) begin
               st = ST_HYPHEN;
            end
            push = 1'b1;
            desc.bank = bank_ff;
            desc.count = fill_in;
            desc.status = st;
            fill_in = '0;
            hyph_in = 1'b0;
            start_in = 1'b1;
            pend_in = 3'd0;
            lead_in = 8'h00;
            pair_in = 1'b0;
            ovf_in = 1'b0;
            first_hy_in = 1'b0;
            bank_in = !bank_ff;
         end
      end

      // Count words closed but not yet drained.
      case ({push, word_done})
         2'b10:   flight_in = flight_ff + 2'd1;
         2'b01:   flight_in = flight_ff - 2'd1;
         default: flight_in = flight_ff;
      endcase
   end

   // Hold word state.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         hyph_ff <= 1'b0;
         start_ff <= 1'b1;
         pend_ff <= 3'd0;
         lead_ff <= 8'h00;
         pair_ff <= 1'b0;
         ovf_ff <= 1'b0;
         first_hy_ff <= 1'b0;
         bank_ff <= 1'b0;
         flight_ff <= 2'd0;
      end else begin
         fill_ff <= fill_in;
         hyph_ff <= hyph_in;
         start_ff <= start_in;
         pend_ff <= pend_in;
         lead_ff <= lead_in;
         pair_ff <= pair_in;
         ovf_ff <= ovf_in;
         first_hy_ff <= first_hy_in;
         bank_ff <= bank_in;
         flight_ff <= flight_in;
      end
   end

   `UWN_CHECK(a_flight_range, clock, reset, flight_ff != 2'd3, "more than two words in flight")
   `UWN_CHECK(a_bank_flip, clock, reset, push |=> bank_ff != $past(bank_ff), "bank did not flip")
   `UWN_CHECK(a_fill_cap, clock, reset, fill_ff <= CNT_W'(MAX_WORD), "fill beyond capacity")

endmodule

/* design/uwn_queue.sv */
// Two-entry queue of finished-word descriptors between front and back.
`include "assert_macros.svh"

module uwn_queue
   import uwn_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  uwn_desc_type push_data,
   input  logic         pop,
   output uwn_desc_type head,
   output logic         empty
);

   uwn_desc_type slot_ff [2];
   logic         wptr_ff, rptr_ff;
   logic [1:0]   cnt_ff, cnt_in;
   logic         full;

   assign empty = (cnt_ff == 2'd0);
   assign full = (cnt_ff == 2'd2);
   assign head = slot_ff[rptr_ff];

   // Track occupancy.
   always_comb begin
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   // Advance pointers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wptr_ff <= !wptr_ff;
         end
         if (pop) begin
            rptr_ff <= !rptr_ff;
         end
         cnt_ff <= cnt_in;
      end
   end

   // Store entries.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

   `UWN_CHECK(a_no_overrun, clock, reset, !(push && full), "push into full queue")
   `UWN_CHECK(a_no_underrun, clock, reset, !(pop && empty), "pop from empty queue")

endmodule

/* design/uwn_back.sv */
// Back end: holds the word store and drains finished words as result items.
`include "assert_macros.svh"

module uwn_back
   import uwn_pkg::*;
#(
   parameter int MAX_WORD = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  uwn_wr_type   wr,
   input  logic         q_empty,
   input  uwn_desc_type q_head,
   output logic         pop,
   uwn_rsp_if.source    rsp,
   output logic         word_done
);

   localparam int HALF = (MAX_WORD + 1) / 2;
   localparam int DEPTH = 2 * HALF;
   localparam int AW = $clog2(DEPTH);

   logic [7:0] mem_even [DEPTH];
   logic [7:0] mem_odd [DEPTH];

   uwn_back_state_type state_ff, state_in;
   logic               bank_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [IDX_W-1:0]   idx_ff;
   uwn_status_type     status_ff;
   logic               sel_ff;
   logic [7:0]         rd_even_ff;
   logic [7:0]         rd_odd_ff;

   logic               accept;
   logic               last;
   logic               rd_en;
   logic               rd_bank;
   logic [IDX_W-1:0]   rd_idx;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      wa_even;
   logic [AW-1:0]      wa_odd;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               state_in = BK_SHOW;
            end
         end
         BK_SHOW: begin
            if (accept && last) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Outputs and read requests.
   always_comb begin
      pop = 1'b0;
      rsp.valid = 1'b0;
      unique case (state_ff)
         BK_IDLE: pop = !q_empty;
         BK_SHOW: rsp.valid = 1'b1;
         default: pop = 1'b0;
      endcase
      accept = rsp.valid && rsp.ready;
      last = (status_ff != ST_BYTE) || (CNT_W'(idx_ff) + CNT_W'(1) == count_ff);
      word_done = accept && last;

      rd_en = 1'b0;
      rd_bank = bank_ff;
      rd_idx = idx_ff + IDX_W'(1);
      if (pop) begin
         rd_en = (q_head.status == ST_BYTE);
         rd_bank = q_head.bank;
         rd_idx = '0;
      end else if (accept && !last) begin
         rd_en = 1'b1;
      end
      rd_addr = rd_bank ? AW'(HALF + int'(rd_idx[IDX_W-1:1])) : AW'(rd_idx[IDX_W-1:1]);

      rsp.out_byte = (status_ff == ST_BYTE) ? (sel_ff ? rd_odd_ff : rd_even_ff) : 8'h00;
      rsp.status = status_ff;
      rsp.run_last = last;
   end

   // Write addresses inside the selected bank.
   assign wa_even = wr.bank ? AW'(HALF + int'(wr.even_idx)) : AW'(wr.even_idx);
   assign wa_odd = wr.bank ? AW'(HALF + int'(wr.odd_idx)) : AW'(wr.odd_idx);

   // Word store: write from the front, registered read for the output.
   always_ff @(posedge clock) begin
      if (wr.even_we) begin
         mem_even[wa_even] <= wr.even_data;
      end
      if (wr.odd_we) begin
         mem_odd[wa_odd] <= wr.odd_data;
      end
      if (rd_en) begin
         rd_even_ff <= mem_even[rd_addr];
         rd_odd_ff <= mem_odd[rd_addr];
         sel_ff <= rd_idx[0];
      end
   end

   // Load a descriptor and advance through the word.
   always_ff @(posedge clock) begin
      if (pop) begin
         bank_ff <= q_head.bank;
         count_ff <= q_head.count;
         status_ff <= q_head.status;
         idx_ff <= '0;
      end else if (accept && !last) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `UWN_CHECK(a_word_bounds, clock, reset, (state_ff == BK_SHOW && status_ff == ST_BYTE) |-> (count_ff != '0 && CNT_W'(idx_ff) < count_ff), "index outside word")
   `UWN_CHECK(a_done_idle, clock, reset, word_done |=> state_ff == BK_IDLE, "no return to idle after word")

endmodule

/* design/utf8_word_normalizer.sv */
// Top level of the UTF-8 word normalizer.
// Takes one byte of a UTF-8 word per cycle on req_if while it is ready and emits
// the normalized word on rsp_if, one byte per item with run_last on the final byte,
// or one status item (empty, hyphen only, truncated UTF-8, too long) when the word
// is dropped. The front end decodes each byte combinationally and writes kept bytes
// into a two-bank word store; a two-word descriptor queue decouples it from the back
// end. Input accepts one byte per cycle as long as fewer than two finished words
// wait to be drained, so one word can be read in while the previous one drains. The
// back end loads a word's descriptor in its idle state, then gives one item per
// cycle while rsp_if is ready and returns to idle once the word's last item is taken;
// results thus appear only after the descriptor has passed through the queue.
module utf8_word_normalizer
   import uwn_pkg::*;
#(
   parameter int MAX_WORD = 64
) (
   input  logic      clock,
   input  logic      reset,
   uwn_req_if.sink   req_if,
   uwn_rsp_if.source rsp_if
);

   logic         push;
   logic         pop;
   logic         q_empty;
   logic         word_done;
   uwn_desc_type push_desc;
   uwn_desc_type head_desc;
   uwn_wr_type   wr;

   uwn_front #(.MAX_WORD(MAX_WORD)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .word_done (word_done),
      .push      (push),
      .desc      (push_desc),
      .wr        (wr)
   );

   uwn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_desc),
      .pop       (pop),
      .head      (head_desc),
      .empty     (q_empty)
   );

   uwn_back #(.MAX_WORD(MAX_WORD)) u_back (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .q_empty   (q_empty),
      .q_head    (head_desc),
      .pop       (pop),
      .rsp       (rsp_if),
      .word_done (word_done)
   );

endmodule

/* sim/tb.sv */
// Testbench of the UTF-8 word normalizer: directed and random words checked item by item.
module tb;
   import uwn_pkg::*;

   localparam int WORD_CAP = 64;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_BYTES = 200;

   typedef struct {
      logic [7:0] data;
      logic       last;
      bit         drain_first;
   } feed_item_type;

   typedef struct {
      logic [7:0]     data;
      uwn_status_type code;
      logic           last;
   } norm_item_type;

   typedef struct packed {
      logic       keep;
      logic [7:0] hi;
      logic [7:0] lo;
   } fold_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       feed_valid = 1'b0;
   logic [7:0] feed_byte = 8'h00;
   logic       feed_end = 1'b0;
   logic       take_ready = 1'b0;

   uwn_req_if req_if();
   uwn_rsp_if rsp_if();

   assign req_if.valid = feed_valid;
   assign req_if.in_byte = feed_byte;
   assign req_if.word_end = feed_end;
   assign rsp_if.ready = take_ready;

   utf8_word_normalizer #(
      .MAX_WORD(WORD_CAP)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   always #5 clock = ~clock;

   // Bytes waiting to be sent, the word under construction, and expected result items
   feed_item_type byte_q[$];
   logic [7:0]    word_buf[$];
   norm_item_type norm_q[$];

   int errors = 0;
   int bytes_in = 0;
   int words_seen = 0;
   int results_seen = 0;
   int outcome_seen [5] = '{default: 0};
   int cycles = 0;

   // Normalizer state as the predictor sees it
   logic [7:0] kept [WORD_CAP];
   int         kept_n = 0;
   bit         hyphen_kept = 1'b0;
   bit         word_start = 1'b1;
   bit         pair_open = 1'b0;
   bit         spilled = 1'b0;
   int         owed = 0;
   logic [7:0] held_lead = 8'h00;

   // Handshake bookkeeping between monitor and driver
   bit feed_fired = 1'b0;
   int gap_left = 0;
   int feed_quiet = 0;
   int stall_left = 0;
   int take_quiet = 0;

   // Symbol length announced by a lead byte
   function automatic int lead_len(input logic [7:0] b);
      if (b < 8'hC0) return 1;
      if (b < 8'hE0) return 2;
      if (b < 8'hF0) return 3;
      if (b < 8'hF8) return 4;
      if (b < 8'hFC) return 5;
      if (b < 8'hFE) return 6;
      if (b == 8'hFE) return 7;
      return 8;
   endfunction

   // Keep Cyrillic letters of a two-byte symbol, folding uppercase to lowercase
   function automatic fold_type fold_cyrillic(input logic [7:0] lead, input logic [7:0] s);
      fold_type f;
      f = '0;
      if (lead == LEAD_D0) begin
         if (s >= 8'h90 && s <= 8'h9F) f = '{1'b1, LEAD_D0, s + CASE_OFFSET};
         else if (s >= 8'hA0 && s <= 8'hAF) f = '{1'b1, LEAD_D1, s - CASE_OFFSET};
         else if (s == YO_UPPER) f = '{1'b1, LEAD_D1, YO_LOWER};
         else if (s >= 8'hB0 && s <= 8'hBF) f = '{1'b1, LEAD_D0, s};
      end else if (lead == LEAD_D1) begin
         if ((s >= 8'h80 && s <= 8'h8F) || s == YO_LOWER) f = '{1'b1, LEAD_D1, s};
      end
      return f;
   endfunction

   // Advance the predictor by one accepted byte; at word end queue the expected items
   task automatic normalize_byte(input logic [7:0] b, input logic last);
      fold_type       f;
      int             n;
      logic [7:0]     v;
      bit             take;
      uwn_status_type outcome;
      take = 1'b0;
      v = b;
      bytes_in++;
      if (owed > 0) begin
         owed--;
         if (pair_open && owed == 0) begin
            f = fold_cyrillic(held_lead, b);
            if (f.keep) begin
               if (kept_n + 2 <= WORD_CAP) begin
                  kept[kept_n] = f.hi;
                  kept[kept_n + 1] = f.lo;
                  kept_n += 2;
               end else begin
                  spilled = 1'b1;
               end
            end
            pair_open = 1'b0;
         end
      end else begin
         n = lead_len(b);
         if (n == 1) begin
            if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
               take = 1'b1;
               v = b + CASE_OFFSET;
            end else if ((b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) ||
                         (b >= CHAR_DIGIT_0 && b <= CHAR_DIGIT_9)) begin
               take = 1'b1;
            end else if (b == CHAR_HYPHEN && !hyphen_kept && !word_start && !last) begin
               take = 1'b1;
               hyphen_kept = 1'b1;
            end
            if (take) begin
               if (kept_n < WORD_CAP) begin
                  kept[kept_n] = v;
                  kept_n++;
               end else begin
                  spilled = 1'b1;
               end
            end
         end else if (n == 2) begin
            held_lead = b;
            pair_open = 1'b1;
            owed = 1;
         end else begin
            pair_open = 1'b0;
            owed = n - 1;
         end
      end
      word_start = 1'b0;

      if (last) begin
         words_seen++;
         if (owed > 0) outcome = ST_TRUNC;
         else if (spilled) outcome = ST_LONG;
         else if (kept_n == 0) outcome = ST_EMPTY;
         else if (kept_n == 1 && kept[0] == CHAR_HYPHEN) outcome = ST_HYPHEN;
         else outcome = ST_BYTE;
         outcome_seen[int'(outcome)]++;
         if (outcome == ST_BYTE) begin
            for (int i = 0; i < kept_n; i++) begin
               norm_q.push_back('{data: kept[i], code: ST_BYTE, last: (i == kept_n - 1)});
            end
         end else begin
            norm_q.push_back('{data: 8'h00, code: outcome, last: 1'b1});
         end
         kept_n = 0;
         hyphen_kept = 1'b0;
         word_start = 1'b1;
         owed = 0;
         held_lead = 8'h00;
         pair_open = 1'b0;
         spilled = 1'b0;
      end
   endtask

   // Idle length: mostly zero or short, a few long, with quiet stretches of none
   function automatic int idle_len(inout int quiet);
      int r;
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      r = int'($urandom_range(0, 99));
      if (r < 2) begin
         quiet = int'($urandom_range(20, 60));
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return int'($urandom_range(1, 3));
      if (r < 97) return int'($urandom_range(4, 12));
      return int'($urandom_range(20, 50));
   endfunction

   function automatic logic [7:0] rand_letter();
      if ($urandom_range(0, 1) == 1) return 8'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z));
      return 8'($urandom_range(CHAR_LOWER_A, CHAR_LOWER_Z));
   endfunction

   // Append one random symbol to the word under construction
   task automatic add_symbol();
      int         r;
      logic [7:0] lead;
      r = int'($urandom_range(0, 99));
      if (r < 25) begin
         word_buf.push_back(rand_letter());
      end else if (r < 35) begin
         word_buf.push_back(8'($urandom_range(CHAR_DIGIT_0, CHAR_DIGIT_9)));
      end else if (r < 45) begin
         word_buf.push_back(CHAR_HYPHEN);
      end else if (r < 70) begin
         word_buf.push_back(($urandom_range(0, 1) == 1) ? LEAD_D1 : LEAD_D0);
         word_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else if (r < 78) begin
         word_buf.push_back(8'($urandom_range(8'hC0, 8'hDF)));
         word_buf.push_back(8'($urandom_range(0, 255)));
      end else if (r < 88) begin
         lead = 8'($urandom_range(8'hE0, 8'hFF));
         word_buf.push_back(lead);
         repeat (lead_len(lead) - 1) word_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
         word_buf.push_back(8'($urandom_range(0, 8'hBF)));
      end
   endtask

   // Append a multi-byte symbol cut short before its last byte
   task automatic add_truncated();
      logic [7:0] lead;
      lead = 8'($urandom_range(8'hC0, 8'hFF));
      word_buf.push_back(lead);
      repeat ($urandom_range(1, lead_len(lead) - 1) - 1)
         word_buf.push_back(8'($urandom_range(0, 255)));
   endtask

   // Move the finished word into the send queue, end mark on its last byte
   task automatic flush_word(input bit drain_first);
      for (int i = 0; i < word_buf.size(); i++) begin
         byte_q.push_back('{data: word_buf[i], last: (i == word_buf.size() - 1),
                            drain_first: (drain_first && i == 0)});
      end
      word_buf.delete();
   endtask

   // Monitor: feed the predictor on accepted bytes, check accepted result items
   always @(posedge clock) begin
      norm_item_type e;
      feed_fired = !reset && req_if.valid && req_if.ready;
      if (feed_fired) normalize_byte(req_if.in_byte, req_if.word_end);
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         if (norm_q.size() == 0) begin
            $error("unexpected result item: out_byte %h status %0d run_last %b",
                   rsp_if.out_byte, rsp_if.status, rsp_if.run_last);
            errors++;
         end else begin
            e = norm_q.pop_front();
            if (rsp_if.out_byte !== e.data) begin
               $error("out_byte: expected %h, got %h", e.data, rsp_if.out_byte);
               errors++;
            end
            if (rsp_if.status !== e.code) begin
               $error("status: expected %0d, got %0d", e.code, rsp_if.status);
               errors++;
            end
            if (rsp_if.run_last !== e.last) begin
               $error("run_last: expected %b, got %b", e.last, rsp_if.run_last);
               errors++;
            end
         end
      end
   end

   // Driver: present the next byte after a random gap, hold it until taken
   always @(negedge clock) begin
      if (reset) begin
         feed_valid <= 1'b0;
      end else begin
         if (feed_fired) begin
            void'(byte_q.pop_front());
            gap_left = idle_len(feed_quiet);
         end
         if (!feed_valid || feed_fired) begin
            if (gap_left > 0) begin
               gap_left--;
               feed_valid <= 1'b0;
            end else if (byte_q.size() != 0 &&
                         !(byte_q[0].drain_first && norm_q.size() != 0)) begin
               feed_valid <= 1'b1;
               feed_byte <= byte_q[0].data;
               feed_end <= byte_q[0].last;
            end else begin
               feed_valid <= 1'b0;
            end
         end
      end
   end

   // Result side: stall at random
   always @(negedge clock) begin
      int n;
      if (reset) begin
         take_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         take_ready <= 1'b0;
      end else begin
         n = idle_len(take_quiet);
         if (n > 0) begin
            stall_left = n - 1;
            take_ready <= 1'b0;
         end else begin
            take_ready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d results still expected", cycles, norm_q.size());
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      int directed_n;
      int r;

      // Directed words: single letter, empty, truncated, hyphen rules, Cyrillic, stray bytes
      word_buf = '{CHAR_UPPER_A};
      flush_word(1'b0);
      word_buf = '{8'h00};
      flush_word(1'b0);
      word_buf = '{8'hFF, 8'h80};
      flush_word(1'b0);
      word_buf = '{8'h21, CHAR_HYPHEN, 8'h21};
      flush_word(1'b0);
      word_buf = '{CHAR_HYPHEN, 8'h62, CHAR_HYPHEN};
      flush_word(1'b0);
      word_buf = '{8'h5A, 8'h39, CHAR_HYPHEN, 8'h7A, CHAR_HYPHEN, 8'h30};
      flush_word(1'b0);
      word_buf = '{LEAD_D0, 8'h90, LEAD_D0, 8'hAF, LEAD_D0, YO_UPPER, LEAD_D1, YO_LOWER};
      flush_word(1'b0);
      word_buf = '{8'h80, 8'hBF};
      flush_word(1'b0);
      directed_n = byte_q.size();

      // Full buffer exactly, then overflow by a two-byte letter
      repeat (WORD_CAP) word_buf.push_back(rand_letter());
      flush_word(1'b1);
      repeat (WORD_CAP - 1) word_buf.push_back(rand_letter());
      word_buf.push_back(LEAD_D0);
      word_buf.push_back(8'($urandom_range(8'hB0, 8'hBF)));
      flush_word(1'b0);

      // Random words: mostly well formed, some cut short, some noise, a few long
      while (byte_q.size() - directed_n < RANDOM_BYTES) begin
         r = int'($urandom_range(0, 99));
         if (r < 3) begin
            repeat ($urandom_range(WORD_CAP - 4, WORD_CAP + 2)) word_buf.push_back(rand_letter());
            if ($urandom_range(0, 1) == 1) add_symbol();
         end else if (r < 63) begin
            repeat ($urandom_range(1, 8)) add_symbol();
         end else if (r < 81) begin
            repeat ($urandom_range(0, 5)) add_symbol();
            add_truncated();
         end else begin
            repeat ($urandom_range(1, 6)) word_buf.push_back(8'($urandom_range(0, 255)));
         end
         flush_word($urandom_range(0, 11) == 0);
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (byte_q.size() != 0) @(posedge clock);
      while (norm_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("tb: %0d bytes in %0d words sent, %0d result items compared",
               bytes_in, words_seen, results_seen);
      $display("tb: outcomes: kept %0d, empty %0d, hyphen only %0d, truncated %0d, too long %0d",
               outcome_seen[int'(ST_BYTE)], outcome_seen[int'(ST_EMPTY)],
               outcome_seen[int'(ST_HYPHEN)], outcome_seen[int'(ST_TRUNC)],
               outcome_seen[int'(ST_LONG)]);
      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+design
design/uwn_pkg.sv
design/uwn_req_if.sv
design/uwn_rsp_if.sv
design/uwn_front.sv
design/uwn_queue.sv
design/uwn_back.sv
design/utf8_word_normalizer.sv
sim/tb.sv
